// ===== hdl/scr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package scr_pkg;

    // Field widths
    localparam int POS_W     = 48;   // Q.16 position / range fields
    localparam int BIAS_W    = 45;   // clock bias, 2^-40 s
    localparam int LS_W      = 30;   // light speed register
    localparam int ER_W      = 52;   // earth rate register
    localparam int CFG_W     = 52;   // config data, widest register
    localparam int CFG_IDX_W = 1;

    // Range unit
    localparam int PX_W    = 50;     // rotated position, signed
    localparam int DSUB_W  = 51;     // receiver minus position, signed
    localparam int DIFF_W  = 50;     // magnitude of the difference
    localparam int HALF_W  = 25;     // square split
    localparam int SQ_W    = 100;    // sum of squares
    localparam int ROOT_W  = 50;     // integer square root

    // Angle unit
    localparam int ER_LO   = 26;
    localparam int RG_LO   = 25;
    localparam int PROD_W  = 102;    // earth_rate * range
    localparam int ANG_W   = 64;     // angle, 2^-80 rad
    localparam int HIGH_W  = PROD_W - ANG_W;

    // Rotation term
    localparam int TV_LO   = 24;
    localparam int TA_LO   = 32;
    localparam int TPROD_W = 112;
    localparam int TRM_W   = 32;     // bits [111:80] of |v| * A

    // Clock term
    localparam int BLO_W   = 23;
    localparam int BPROD_W = 75;
    localparam int CLK_W   = 51;
    localparam int SUM_W   = 54;

    localparam logic [LS_W-1:0] LIGHT_SPEED_RST = 30'd299792458;
    localparam logic [ER_W-1:0] EARTH_RATE_RST  = 52'd1345157820000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIGHT_SPEED = 1'b0,
        REG_EARTH_RATE  = 1'b1
    } cfg_reg_t;

    // Per-item context that rides along the pipeline
    typedef struct packed {
        logic signed [POS_W-1:0] sat_x;
        logic signed [POS_W-1:0] sat_y;
        logic signed [POS_W-1:0] sat_z;
        logic signed [POS_W-1:0] rx_x;
        logic signed [POS_W-1:0] rx_y;
        logic signed [POS_W-1:0] rx_z;
        logic        [POS_W-1:0] sx_mag;
        logic        [POS_W-1:0] sy_mag;
        logic        [CLK_W-1:0] clk_mag;
        logic                    bias_neg;
        logic signed [POS_W-1:0] corr;
    } ctx_t;

endpackage

`default_nettype wire

// ===== hdl/sagnac_corrected_range_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Ports                                   | Dir | Handshake
// ----------+-----------------------------------------+-----+----------------------
// input     | s_sat_*, s_rx_*, s_clock_bias, s_range_* | in  | s_valid / s_ready
// result    | m_corrected_range                        | out | m_valid / m_ready
// config    | cfg_index, cfg_data                      | in  | cfg_wr_en, no wait
//
// One beat enters per cycle unless the result is stalled; P = ROTATION_PASSES.
// The pipeline holds the bit-per-stage square root (50 stages per range)
// and the bit-per-stage angle divider (64 stages per pass).
// aresetn is synchronous: it clears the valid bits and loads the register defaults.
// A stalled result freezes the whole pipeline in place; nothing is dropped or repeated.
module sagnac_corrected_range_top #(
    parameter int ROTATION_PASSES = 2
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire  signed [scr_pkg::POS_W-1:0]  s_sat_x,
    input  wire  signed [scr_pkg::POS_W-1:0]  s_sat_y,
    input  wire  signed [scr_pkg::POS_W-1:0]  s_sat_z,
    input  wire  signed [scr_pkg::POS_W-1:0]  s_rx_x,
    input  wire  signed [scr_pkg::POS_W-1:0]  s_rx_y,
    input  wire  signed [scr_pkg::POS_W-1:0]  s_rx_z,
    input  wire  signed [scr_pkg::BIAS_W-1:0] s_clock_bias,
    input  wire  signed [scr_pkg::POS_W-1:0]  s_range_correction,
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic signed [scr_pkg::POS_W-1:0]  m_corrected_range,
    input  wire                               cfg_wr_en,
    input  wire         [scr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire         [scr_pkg::CFG_W-1:0]  cfg_data
);
    import scr_pkg::*;

    localparam int P = ROTATION_PASSES;

    logic              pipe_adv;
    logic [LS_W-1:0]   light_speed_reg;
    logic [ER_W-1:0]   earth_rate_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_speed_reg <= LIGHT_SPEED_RST;
            earth_rate_reg  <= EARTH_RATE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LIGHT_SPEED: light_speed_reg <= cfg_data[LS_W-1:0];
                REG_EARTH_RATE:  earth_rate_reg  <= cfg_data[ER_W-1:0];
                default: ;
            endcase
        end
    end

    // Whole pipeline moves together unless the output beat is stalled
    logic out_vld_reg;
    assign pipe_adv = !out_vld_reg || m_ready;
    assign s_ready  = pipe_adv;

    // ---------------------------------------------------------------
    // Entry stages: capture, clock-bias term
    // ---------------------------------------------------------------
    logic                 e_vld_reg, f_vld_reg, g_vld_reg;
    ctx_t                 e_ctx_reg, f_ctx_reg, g_ctx_reg;
    logic [BIAS_W-1:0]    e_bmag_reg;
    logic [BLO_W+LS_W-1:0]          f_pl_reg;
    logic [BIAS_W-BLO_W+LS_W-1:0]   f_ph_reg;
    ctx_t                 e_ctx_next;
    ctx_t                 g_ctx_next;
    logic [BPROD_W-1:0]   g_prod;

    always_comb begin
        e_ctx_next.sat_x    = s_sat_x;
        e_ctx_next.sat_y    = s_sat_y;
        e_ctx_next.sat_z    = s_sat_z;
        e_ctx_next.rx_x     = s_rx_x;
        e_ctx_next.rx_y     = s_rx_y;
        e_ctx_next.rx_z     = s_rx_z;
        e_ctx_next.sx_mag   = s_sat_x[POS_W-1] ? POS_W'(-s_sat_x) : POS_W'(s_sat_x);
        e_ctx_next.sy_mag   = s_sat_y[POS_W-1] ? POS_W'(-s_sat_y) : POS_W'(s_sat_y);
        e_ctx_next.clk_mag  = '0;
        e_ctx_next.bias_neg = s_clock_bias[BIAS_W-1];
        e_ctx_next.corr     = s_range_correction;
        g_prod = {f_ph_reg, {BLO_W{1'b0}}} + BPROD_W'(f_pl_reg);
        g_ctx_next         = f_ctx_reg;
        g_ctx_next.clk_mag = g_prod[BPROD_W-1:BPROD_W-CLK_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
        end else if (pipe_adv) begin
            e_vld_reg <= s_valid;
            f_vld_reg <= e_vld_reg;
            g_vld_reg <= f_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            e_ctx_reg  <= e_ctx_next;
            e_bmag_reg <= s_clock_bias[BIAS_W-1] ? BIAS_W'(-s_clock_bias)
                                                 : BIAS_W'(s_clock_bias);
            f_ctx_reg  <= e_ctx_reg;
            f_pl_reg   <= e_bmag_reg[BLO_W-1:0] * light_speed_reg;
            f_ph_reg   <= e_bmag_reg[BIAS_W-1:BLO_W] * light_speed_reg;
            g_ctx_reg  <= g_ctx_next;
        end
    end

    // Links between the range and rotation units
    logic                   pos_vld [P+1];
    ctx_t                   pos_ctx [P+1];
    logic signed [PX_W-1:0] pos_x   [P+1];
    logic signed [PX_W-1:0] pos_y   [P+1];
    logic                   rng_vld [P+1];
    ctx_t                   rng_ctx [P+1];
    logic [ROOT_W-1:0]      rng_val [P+1];

    assign pos_vld[0] = g_vld_reg;
    assign pos_ctx[0] = g_ctx_reg;
    assign pos_x[0]   = PX_W'(g_ctx_reg.sat_x);
    assign pos_y[0]   = PX_W'(g_ctx_reg.sat_y);

    for (genvar p = 0; p <= P; p++) begin : g_pass

        // -----------------------------------------------------------
        // Range unit: differences, squares, sum, square root
        // -----------------------------------------------------------
        logic                   va_reg, vb_reg, vc_reg, vd_reg;
        ctx_t                   ca_reg, cb_reg, cc_reg, cd_reg;
        logic [DIFF_W-1:0]      ma_reg  [3];
        logic [2*HALF_W-1:0]    ll_reg  [3];
        logic [2*HALF_W-1:0]    lh_reg  [3];
        logic [2*HALF_W-1:0]    hh_reg  [3];
        logic [SQ_W-1:0]        sqa_reg [3];
        logic [SQ_W-1:0]        nd_reg;
        logic signed [DSUB_W-1:0] dsub  [3];
        logic [DIFF_W-1:0]      ma_next [3];

        logic                   sv_reg    [ROOT_W];
        ctx_t                   sc_reg    [ROOT_W];
        logic [SQ_W-1:0]        srem_reg  [ROOT_W];
        logic [ROOT_W-1:0]      sroot_reg [ROOT_W];
        logic [SQ_W-1:0]        srem_next [ROOT_W];
        logic [ROOT_W-1:0]      sroot_next[ROOT_W];

        // Receiver minus satellite, magnitude per axis
        always_comb begin
            dsub[0] = DSUB_W'(pos_ctx[p].rx_x) - DSUB_W'(pos_x[p]);
            dsub[1] = DSUB_W'(pos_ctx[p].rx_y) - DSUB_W'(pos_y[p]);
            dsub[2] = DSUB_W'(pos_ctx[p].rx_z) - DSUB_W'(pos_ctx[p].sat_z);
            for (int a = 0; a < 3; a++) begin
                ma_next[a] = dsub[a][DSUB_W-1] ? DIFF_W'(-dsub[a]) : DIFF_W'(dsub[a]);
            end
        end

        // Square root, one result bit per stage
        always_comb begin
            logic [SQ_W-1:0]   rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [SQ_W-1:0]   trial;
            for (int k = 0; k < ROOT_W; k++) begin
                if (k == 0) begin
                    rem_in  = nd_reg;
                    root_in = '0;
                end else begin
                    rem_in  = srem_reg[k-1];
                    root_in = sroot_reg[k-1];
                end
                trial = (SQ_W'(root_in) << (ROOT_W - k))
                      | (SQ_W'(1) << (2 * (ROOT_W - 1 - k)));
                if (rem_in >= trial) begin
                    srem_next[k]  = rem_in - trial;
                    sroot_next[k] = root_in | (ROOT_W'(1) << (ROOT_W - 1 - k));
                end else begin
                    srem_next[k]  = rem_in;
                    sroot_next[k] = root_in;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                va_reg <= 1'b0;
                vb_reg <= 1'b0;
                vc_reg <= 1'b0;
                vd_reg <= 1'b0;
                for (int k = 0; k < ROOT_W; k++) sv_reg[k] <= 1'b0;
            end else if (pipe_adv) begin
                va_reg <= pos_vld[p];
                vb_reg <= va_reg;
                vc_reg <= vb_reg;
                vd_reg <= vc_reg;
                for (int k = 0; k < ROOT_W; k++) begin
                    sv_reg[k] <= (k == 0) ? vd_reg : sv_reg[k-1];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (pipe_adv) begin
                ca_reg <= pos_ctx[p];
                cb_reg <= ca_reg;
                cc_reg <= cb_reg;
                cd_reg <= cc_reg;
                for (int a = 0; a < 3; a++) begin
                    ma_reg[a]  <= ma_next[a];
                    ll_reg[a]  <= ma_reg[a][HALF_W-1:0] * ma_reg[a][HALF_W-1:0];
                    lh_reg[a]  <= ma_reg[a][HALF_W-1:0] * ma_reg[a][DIFF_W-1:HALF_W];
                    hh_reg[a]  <= ma_reg[a][DIFF_W-1:HALF_W] * ma_reg[a][DIFF_W-1:HALF_W];
                    sqa_reg[a] <= {hh_reg[a], {(2*HALF_W){1'b0}}}
                                + SQ_W'({lh_reg[a], {(HALF_W+1){1'b0}}})
                                + SQ_W'(ll_reg[a]);
                end
                nd_reg <= sqa_reg[0] + sqa_reg[1] + sqa_reg[2];
                for (int k = 0; k < ROOT_W; k++) begin
                    sc_reg[k]    <= (k == 0) ? cd_reg : sc_reg[k-1];
                    srem_reg[k]  <= srem_next[k];
                    sroot_reg[k] <= sroot_next[k];
                end
            end
        end

        assign rng_vld[p] = sv_reg[ROOT_W-1];
        assign rng_ctx[p] = sc_reg[ROOT_W-1];
        assign rng_val[p] = sroot_reg[ROOT_W-1];

        // -----------------------------------------------------------
        // Rotation unit: angle, divide, rotate satellite x/y
        // -----------------------------------------------------------
        if (p < P) begin : g_rot
            logic                     m1_vld_reg, m2_vld_reg, m3_vld_reg;
            ctx_t                     m1_ctx_reg, m2_ctx_reg, m3_ctx_reg;
            logic [ER_W-ER_LO+ROOT_W-RG_LO-1:0] m1_hh_reg;
            logic [ER_W-ER_LO+RG_LO-1:0]        m1_hl_reg;
            logic [ER_LO+ROOT_W-RG_LO-1:0]      m1_lh_reg;
            logic [ER_LO+RG_LO-1:0]             m1_ll_reg;
            logic [PROD_W-1:0]        m2_t_reg;
            logic                     m3_sat_reg;
            logic [LS_W-1:0]          m3_rem_reg;
            logic [ANG_W-1:0]         m3_low_reg;

            logic                     dv_reg   [ANG_W];
            ctx_t                     dc_reg   [ANG_W];
            logic                     dsat_reg [ANG_W];
            logic [LS_W-1:0]          drem_reg [ANG_W];
            logic [ANG_W-1:0]         dlow_reg [ANG_W];
            logic [ANG_W-1:0]         dq_reg   [ANG_W];
            logic [LS_W-1:0]          drem_next[ANG_W];
            logic [ANG_W-1:0]         dq_next  [ANG_W];

            logic                     t1_vld_reg, t2_vld_reg, t3_vld_reg;
            ctx_t                     t1_ctx_reg, t2_ctx_reg, t3_ctx_reg;
            logic [TV_LO+TA_LO-1:0]   t1_ll_reg [2];
            logic [TV_LO+TA_LO-1:0]   t1_lh_reg [2];
            logic [TV_LO+TA_LO-1:0]   t1_hl_reg [2];
            logic [TV_LO+TA_LO-1:0]   t1_hh_reg [2];
            logic [TRM_W-1:0]         t2_trm_reg[2];
            logic signed [PX_W-1:0]   t3_x_reg, t3_y_reg;

            logic [ANG_W-1:0]         ang;
            logic [POS_W-1:0]         vmag [2];
            logic [TPROD_W-1:0]       tprod[2];
            ctx_t                     dc_last;

            // Long division by light speed, one quotient bit per stage
            always_comb begin
                logic [LS_W-1:0]  rem_in;
                logic [ANG_W-1:0] q_in;
                logic [ANG_W-1:0] low_in;
                logic [LS_W:0]    cur;
                for (int k = 0; k < ANG_W; k++) begin
                    if (k == 0) begin
                        rem_in = m3_rem_reg;
                        q_in   = '0;
                        low_in = m3_low_reg;
                    end else begin
                        rem_in = drem_reg[k-1];
                        q_in   = dq_reg[k-1];
                        low_in = dlow_reg[k-1];
                    end
                    cur = {rem_in, low_in[ANG_W-1-k]};
                    if (cur >= (LS_W+1)'(light_speed_reg)) begin
                        drem_next[k] = LS_W'(cur - (LS_W+1)'(light_speed_reg));
                        dq_next[k]   = q_in | (ANG_W'(1) << (ANG_W - 1 - k));
                    end else begin
                        drem_next[k] = cur[LS_W-1:0];
                        dq_next[k]   = q_in;
                    end
                end
            end

            // Saturated angle and rotation-term products
            always_comb begin
                dc_last = dc_reg[ANG_W-1];
                ang     = dsat_reg[ANG_W-1] ? '1 : dq_reg[ANG_W-1];
                vmag[0] = dc_last.sx_mag;
                vmag[1] = dc_last.sy_mag;
                for (int a = 0; a < 2; a++) begin
                    tprod[a] = {t1_hh_reg[a], {(TV_LO+TA_LO){1'b0}}}
                             + TPROD_W'({t1_hl_reg[a], {TV_LO{1'b0}}})
                             + TPROD_W'({t1_lh_reg[a], {TA_LO{1'b0}}})
                             + TPROD_W'(t1_ll_reg[a]);
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    m1_vld_reg <= 1'b0;
                    m2_vld_reg <= 1'b0;
                    m3_vld_reg <= 1'b0;
                    t1_vld_reg <= 1'b0;
                    t2_vld_reg <= 1'b0;
                    t3_vld_reg <= 1'b0;
                    for (int k = 0; k < ANG_W; k++) dv_reg[k] <= 1'b0;
                end else if (pipe_adv) begin
                    m1_vld_reg <= rng_vld[p];
                    m2_vld_reg <= m1_vld_reg;
                    m3_vld_reg <= m2_vld_reg;
                    for (int k = 0; k < ANG_W; k++) begin
                        dv_reg[k] <= (k == 0) ? m3_vld_reg : dv_reg[k-1];
                    end
                    t1_vld_reg <= dv_reg[ANG_W-1];
                    t2_vld_reg <= t1_vld_reg;
                    t3_vld_reg <= t2_vld_reg;
                end
            end

            always_ff @(posedge aclk) begin
                if (pipe_adv) begin
                    // earth_rate * range
                    m1_ctx_reg <= rng_ctx[p];
                    m1_hh_reg  <= earth_rate_reg[ER_W-1:ER_LO] * rng_val[p][ROOT_W-1:RG_LO];
                    m1_hl_reg  <= earth_rate_reg[ER_W-1:ER_LO] * rng_val[p][RG_LO-1:0];
                    m1_lh_reg  <= earth_rate_reg[ER_LO-1:0] * rng_val[p][ROOT_W-1:RG_LO];
                    m1_ll_reg  <= earth_rate_reg[ER_LO-1:0] * rng_val[p][RG_LO-1:0];
                    m2_ctx_reg <= m1_ctx_reg;
                    m2_t_reg   <= {m1_hh_reg, {(ER_LO+RG_LO){1'b0}}}
                                + PROD_W'({m1_hl_reg, {ER_LO{1'b0}}})
                                + PROD_W'({m1_lh_reg, {RG_LO{1'b0}}})
                                + PROD_W'(m1_ll_reg);
                    // quotient overflows 64 bits (or zero divisor) -> saturate
                    m3_ctx_reg <= m2_ctx_reg;
                    m3_sat_reg <= m2_t_reg[PROD_W-1:ANG_W] >= HIGH_W'(light_speed_reg);
                    m3_rem_reg <= m2_t_reg[ANG_W+LS_W-1:ANG_W];
                    m3_low_reg <= m2_t_reg[ANG_W-1:0];
                    for (int k = 0; k < ANG_W; k++) begin
                        dc_reg[k]   <= (k == 0) ? m3_ctx_reg : dc_reg[k-1];
                        dsat_reg[k] <= (k == 0) ? m3_sat_reg : dsat_reg[k-1];
                        dlow_reg[k] <= (k == 0) ? m3_low_reg : dlow_reg[k-1];
                        drem_reg[k] <= drem_next[k];
                        dq_reg[k]   <= dq_next[k];
                    end
                    // |v| * angle partial products
                    t1_ctx_reg <= dc_last;
                    for (int a = 0; a < 2; a++) begin
                        t1_ll_reg[a] <= vmag[a][TV_LO-1:0] * ang[TA_LO-1:0];
                        t1_lh_reg[a] <= vmag[a][TV_LO-1:0] * ang[ANG_W-1:TA_LO];
                        t1_hl_reg[a] <= vmag[a][POS_W-1:TV_LO] * ang[TA_LO-1:0];
                        t1_hh_reg[a] <= vmag[a][POS_W-1:TV_LO] * ang[ANG_W-1:TA_LO];
                        t2_trm_reg[a] <= tprod[a][TPROD_W-1:TPROD_W-TRM_W];
                    end
                    t2_ctx_reg <= t1_ctx_reg;
                    // x' = x + T(y), y' = y - T(x), T truncating toward zero
                    t3_ctx_reg <= t2_ctx_reg;
                    t3_x_reg <= t2_ctx_reg.sat_y[POS_W-1]
                              ? PX_W'(t2_ctx_reg.sat_x) - PX_W'(t2_trm_reg[1])
                              : PX_W'(t2_ctx_reg.sat_x) + PX_W'(t2_trm_reg[1]);
                    t3_y_reg <= t2_ctx_reg.sat_x[POS_W-1]
                              ? PX_W'(t2_ctx_reg.sat_y) + PX_W'(t2_trm_reg[0])
                              : PX_W'(t2_ctx_reg.sat_y) - PX_W'(t2_trm_reg[0]);
                end
            end

            assign pos_vld[p+1] = t3_vld_reg;
            assign pos_ctx[p+1] = t3_ctx_reg;
            assign pos_x[p+1]   = t3_x_reg;
            assign pos_y[p+1]   = t3_y_reg;
        end
    end

    // ---------------------------------------------------------------
    // Final sum, saturation, output register
    // ---------------------------------------------------------------
    logic                    z_vld_reg;
    logic signed [SUM_W-1:0] z_sum_reg;
    logic signed [SUM_W-1:0] z_rr, z_cc, z_co;
    logic signed [POS_W-1:0] out_data_reg;
    logic                    z_fits;
    ctx_t                    fin_ctx;

    always_comb begin
        fin_ctx = rng_ctx[P];
        z_rr = SUM_W'(rng_val[P]);
        z_cc = SUM_W'(fin_ctx.clk_mag);
        z_co = SUM_W'(fin_ctx.corr);
        z_fits = (z_sum_reg[SUM_W-1:POS_W-1] == '0) || (z_sum_reg[SUM_W-1:POS_W-1] == '1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            z_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (pipe_adv) begin
            z_vld_reg   <= rng_vld[P];
            out_vld_reg <= z_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            z_sum_reg <= fin_ctx.bias_neg ? z_rr + z_cc - z_co : z_rr - z_cc - z_co;
            if (z_fits) begin
                out_data_reg <= z_sum_reg[POS_W-1:0];
            end else begin
                out_data_reg <= {z_sum_reg[SUM_W-1], {(POS_W-1){~z_sum_reg[SUM_W-1]}}};
            end
        end
    end

    assign m_valid           = out_vld_reg;
    assign m_corrected_range = out_data_reg;

endmodule

`default_nettype wire
